@@ rtl/core/clut_tile_blitter_macros.svh @@
// Assertion macros shared by the checker files of the tile blitter.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef CLUT_TILE_BLITTER_MACROS_SVH
`define CLUT_TILE_BLITTER_MACROS_SVH

// Same-cycle implication.
`define CLUTB_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define CLUTB_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/core/clutb_pkg.sv @@
// ----------------------------------------------------------------------------
// clutb_pkg
// Types, codes and constants shared by the tile blitter modules.
// ----------------------------------------------------------------------------
package clutb_pkg;

	localparam int TILE_SIZE_DEF   = 8;
	localparam int FRAME_WIDTH_DEF = 320;

	localparam int TILE_COUNT  = 256;
	localparam int TILE_SLOTS  = 64;
	localparam int CLUT_DEPTH  = 256;
	localparam int MAX_Y_LIMIT = 1024;

	localparam int TILE_AW  = 8;
	localparam int OFFS_W   = 6;
	localparam int PIX_W    = 8;
	localparam int COLOUR_W = 16;
	localparam int POS_W    = 11;
	localparam int COORD_W  = 10;
	localparam int FH_W     = 11;
	localparam int STORE_AW = TILE_AW + OFFS_W;

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 11;

	localparam logic [1:0] FUNC_LOAD_COLOUR = 2'd0;
	localparam logic [1:0] FUNC_LOAD_PIXEL  = 2'd1;
	localparam logic [1:0] FUNC_BLIT_OPAQUE = 2'd2;
	localparam logic [1:0] FUNC_BLIT_MASKED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT  = 1'd1;

	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 11'd320;
	localparam logic [PIX_W-1:0] TRANSPARENT_RST = 8'd0;

	typedef struct packed {
		logic                colour_we;
		logic [PIX_W-1:0]    colour_slot;
		logic [COLOUR_W-1:0] colour_word;
		logic                pixel_we;
		logic [STORE_AW-1:0] pixel_waddr;
		logic [PIX_W-1:0]    pixel_value;
		logic [TILE_AW-1:0]  query_tile;
		logic                pixel_re;
		logic [STORE_AW-1:0] pixel_raddr;
		logic                colour_re;
		logic [PIX_W-1:0]    colour_raddr;
	} mem_req_t;

	typedef struct packed {
		logic                present;
		logic [PIX_W-1:0]    pixel;
		logic [COLOUR_W-1:0] colour;
	} mem_rsp_t;

endpackage

@@ rtl/core/clutb_store.sv @@
// ----------------------------------------------------------------------------
// clutb_store
// Tile pixel store, colour table and per-tile valid marks.
// ----------------------------------------------------------------------------
module clutb_store
	import clutb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	logic [PIX_W-1:0]    tile_mem [TILE_COUNT*TILE_SLOTS];
	logic [COLOUR_W-1:0] clut_mem [CLUT_DEPTH];
	logic [TILE_COUNT-1:0] present_q;
	logic [PIX_W-1:0]    pixel_q;
	logic [COLOUR_W-1:0] colour_q;

	always_ff @(posedge clk) begin
		if (req.pixel_we) begin
			tile_mem[req.pixel_waddr] <= req.pixel_value;
		end
		if (req.pixel_re) begin
			pixel_q <= tile_mem[req.pixel_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.colour_we) begin
			clut_mem[req.colour_slot] <= req.colour_word;
		end
		if (req.colour_re) begin
			colour_q <= clut_mem[req.colour_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (req.pixel_we) begin
			present_q[req.pixel_waddr[STORE_AW-1:OFFS_W]] <= 1'b1;
		end
	end

	assign rsp.present = present_q[req.query_tile];
	assign rsp.pixel   = pixel_q;
	assign rsp.colour  = colour_q;

endmodule

@@ rtl/core/clutb_seq.sv @@
// ----------------------------------------------------------------------------
// clutb_seq
// Blit sequencer: walks the tile with one shared clip unit and stages writes.
// ----------------------------------------------------------------------------
module clutb_seq
	import clutb_pkg::*;
#(
	parameter int TILE_SIZE   = TILE_SIZE_DEF,
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [TILE_AW-1:0]   tile_index,
	input  logic [OFFS_W-1:0]    pixel_offset,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic [PIX_W-1:0]     palette_slot,
	input  logic [COLOUR_W-1:0]  colour_word,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [FH_W-1:0]      frame_height,
	input  logic [PIX_W-1:0]     transparent_index,
	output mem_req_t             req,
	input  mem_rsp_t             rsp,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COORD_W-1:0]   out_x,
	output logic [COORD_W-1:0]   out_y,
	output logic [COLOUR_W-1:0]  out_colour,
	output logic                 last_write
);

	localparam int CW = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(TILE_SIZE - 1);
	localparam logic [POS_W-1:0] WLIM = POS_W'(FRAME_WIDTH);
	localparam logic [FH_W-1:0] HMAX = FH_W'(MAX_Y_LIMIT);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PIX   = 5'b00010,
		S_LUT   = 5'b00100,
		S_PUT   = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] tx_q, ty_q;
	logic hold_v_q, out_v_q;
	logic masked_q, last_q;
	logic [TILE_AW-1:0] tile_q;
	logic [POS_W-1:0] px_q, py_q;
	logic [COORD_W-1:0] cur_x_q, cur_y_q, hold_x_q, hold_y_q, out_x_q, out_y_q;
	logic [COLOUR_W-1:0] hold_c_q, out_c_q;

	logic in_accept, start, adv, ld_hold, ld_out, out_last_d, hold_clr;
	logic rd_pix, rd_clr, last_pix, pix_in, out_free;
	logic [POS_W:0] sx, sy;
	logic [FH_W-1:0] hlim;
	logic [OFFS_W-1:0] tile_off;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign start = in_accept && func[1] && rsp.present;
	assign out_free = !out_v_q || out_ready;
	assign last_pix = (tx_q == CNT_LAST) && (ty_q == CNT_LAST);

	assign hlim = (frame_height > HMAX) ? HMAX : frame_height;
	assign sx = {px_q[POS_W-1], px_q} + (POS_W+1)'(tx_q);
	assign sy = {py_q[POS_W-1], py_q} + (POS_W+1)'(ty_q);
	assign pix_in = !sx[POS_W] && (sx[POS_W-1:0] < WLIM)
		&& !sy[POS_W] && (sy[POS_W-1:0] < hlim);
	assign tile_off = OFFS_W'(ty_q) * OFFS_W'(TILE_SIZE) + OFFS_W'(tx_q);

	always_comb begin
		state_d    = state_q;
		adv        = 1'b0;
		ld_hold    = 1'b0;
		ld_out     = 1'b0;
		out_last_d = 1'b0;
		hold_clr   = 1'b0;
		rd_pix     = 1'b0;
		rd_clr     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_PIX;
			end
			S_PIX: begin
				if (pix_in) begin
					rd_pix  = 1'b1;
					state_d = S_LUT;
				end else begin
					adv = 1'b1;
				end
			end
			S_LUT: begin
				if (masked_q && (rsp.pixel == transparent_index)) begin
					adv = 1'b1;
				end else begin
					rd_clr  = 1'b1;
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (!hold_v_q) begin
					ld_hold = 1'b1;
					adv     = 1'b1;
				end else if (out_free) begin
					ld_out  = 1'b1;
					ld_hold = 1'b1;
					adv     = 1'b1;
				end
			end
			S_FLUSH: begin
				if (!hold_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					ld_out     = 1'b1;
					out_last_d = 1'b1;
					hold_clr   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (adv) state_d = last_pix ? S_FLUSH : S_PIX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tx_q     <= '0;
			ty_q     <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				tx_q <= '0;
				ty_q <= '0;
			end else if (adv) begin
				if (tx_q == CNT_LAST) begin
					tx_q <= '0;
					ty_q <= ty_q + CW'(1);
				end else begin
					tx_q <= tx_q + CW'(1);
				end
			end
			if (ld_hold) hold_v_q <= 1'b1;
			else if (hold_clr) hold_v_q <= 1'b0;
			if (ld_out) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tile_q   <= tile_index;
			masked_q <= (func == FUNC_BLIT_MASKED);
			px_q     <= pos_x;
			py_q     <= pos_y;
		end
		if (rd_pix) begin
			cur_x_q <= sx[COORD_W-1:0];
			cur_y_q <= sy[COORD_W-1:0];
		end
		if (ld_hold) begin
			hold_x_q <= cur_x_q;
			hold_y_q <= cur_y_q;
			hold_c_q <= rsp.colour;
		end
		if (ld_out) begin
			out_x_q <= hold_x_q;
			out_y_q <= hold_y_q;
			out_c_q <= hold_c_q;
			last_q  <= out_last_d;
		end
	end

	always_comb begin
		req.colour_we    = in_accept && (func == FUNC_LOAD_COLOUR);
		req.colour_slot  = palette_slot;
		req.colour_word  = colour_word;
		req.pixel_we     = in_accept && (func == FUNC_LOAD_PIXEL)
			&& ({1'b0, pixel_offset} < (OFFS_W+1)'(TILE_SIZE * TILE_SIZE));
		req.pixel_waddr  = {tile_index, pixel_offset};
		req.pixel_value  = pixel_value;
		req.query_tile   = tile_index;
		req.pixel_re     = rd_pix;
		req.pixel_raddr  = {tile_q, tile_off};
		req.colour_re    = rd_clr;
		req.colour_raddr = rsp.pixel;
	end

	assign out_valid  = out_v_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_colour = out_c_q;
	assign last_write = last_q;

endmodule

@@ rtl/core/clut_tile_blitter.sv @@
// Loads (colour entry or tile pixel) leave the block ready.
// A blit walks all TILE_SIZE*TILE_SIZE pixels: a clipped one is skipped in S_PIX,
// a transparent one after its tile read in S_LUT; a drawn one waits in S_PUT
// for its colour and a free output, and S_FLUSH then sends the final write.
// A write leaves one request after its successor is found, the last at flush.
// Reset clears the tile valid marks and loads the register defaults.
// ----------------------------------------------------------------------------
// clut_tile_blitter
// Tile blitter with colour table lookup, streaming in and out.
// ----------------------------------------------------------------------------
module clut_tile_blitter
	import clutb_pkg::*;
#(
	parameter int TILE_SIZE   = TILE_SIZE_DEF,
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tile_index, pixel_offset, pixel_value, palette_slot, colour_word, pos_x, pos_y
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_x, out_y, out_colour
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [FH_W-1:0]     frame_height_q;
	logic [PIX_W-1:0]    transparent_q;
	mem_req_t            req;
	mem_rsp_t            rsp;
	logic [COORD_W-1:0]  out_x, out_y;
	logic [COLOUR_W-1:0] out_colour;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= FRAME_HEIGHT_RST;
			transparent_q  <= TRANSPARENT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_TRANSPARENT:  transparent_q  <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	clutb_seq #(
		.TILE_SIZE   (TILE_SIZE),
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.func              (s_tuser),
		.tile_index        (s_tdata[7:0]),
		.pixel_offset      (s_tdata[13:8]),
		.pixel_value       (s_tdata[21:14]),
		.palette_slot      (s_tdata[29:22]),
		.colour_word       (s_tdata[45:30]),
		.pos_x             (s_tdata[56:46]),
		.pos_y             (s_tdata[67:57]),
		.frame_height      (frame_height_q),
		.transparent_index (transparent_q),
		.req               (req),
		.rsp               (rsp),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_x             (out_x),
		.out_y             (out_y),
		.out_colour        (out_colour),
		.last_write        (m_tlast)
	);

	clutb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign m_tdata = {4'b0000, out_colour, out_y, out_x};

endmodule

@@ rtl/core/clutb_checker.sv @@
// ----------------------------------------------------------------------------
// clutb_checker
// Port-level checks of the tile blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "clut_tile_blitter_macros.svh"

module clutb_checker
	import clutb_pkg::*;
#(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TUSER_W-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast
);

	`CLUTB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "stalled write dropped")
	`CLUTB_ASSERT_IMP(a_busy_mid_blit, m_tvalid && !m_tlast, !s_tready, "ready during blit")
	`CLUTB_ASSERT_NXT(a_load_one_cycle, s_tvalid && s_tready && !s_tuser[1], s_tready, "load stalled")
	`CLUTB_ASSERT_IMP(a_x_clipped, m_tvalid, m_tdata[9:0] < FRAME_WIDTH, "column outside frame")

endmodule

bind clut_tile_blitter clutb_checker #(.FRAME_WIDTH(FRAME_WIDTH)) u_chk (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tile blitter. It loads a small palette and a few
// tiles, then runs a table of directed blits and loads, and after that several
// random phases under different frame heights and transparent indexes. Every
// framebuffer write is checked against a local blitter model or a typed expected write.
// ----------------------------------------------------------------------------
module testbench;
	import clutb_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int TILE_EDGE = TILE_SIZE_DEF;
	localparam int TILE_AREA = TILE_SIZE_DEF * TILE_SIZE_DEF;
	localparam int FB_WIDTH = FRAME_WIDTH_DEF;
	localparam int FLUSH_CYCLES = 3 * TILE_AREA + 16;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int PHASES = 6;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [1:0] OUTCOME_MODEL = 2'd0;
	localparam logic [1:0] OUTCOME_NONE  = 2'd1;
	localparam logic [1:0] OUTCOME_ONE   = 2'd2;

	typedef struct packed {
		logic [3:0]          pad;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    pos_x;
		logic [COLOUR_W-1:0] colour_word;
		logic [PIX_W-1:0]    palette_slot;
		logic [PIX_W-1:0]    pixel_value;
		logic [OFFS_W-1:0]   pixel_offset;
		logic [TILE_AW-1:0]  tile_index;
	} tile_req_t;

	typedef struct packed {
		logic [3:0]          pad;
		logic [COLOUR_W-1:0] colour;
		logic [COORD_W-1:0]  y;
		logic [COORD_W-1:0]  x;
	} fb_word_t;

	typedef struct packed {
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} fb_write_t;

	typedef struct packed {
		logic [1:0] fn;
		tile_req_t  rq;
		logic [1:0] outcome;
		fb_write_t  typed;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	clut_tile_blitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [COLOUR_W-1:0] clut_shadow [CLUT_DEPTH];
	logic [PIX_W-1:0]    tile_shadow [TILE_COUNT][TILE_SLOTS];
	bit                  tile_valid [TILE_COUNT];
	logic [FH_W-1:0]     frame_height_q;
	logic [PIX_W-1:0]    transparent_q;

	bit                  tile_full [TILE_COUNT];
	logic [TILE_AW-1:0]  full_tiles [$];
	bit                  slot_loaded [CLUT_DEPTH];
	logic [PIX_W-1:0]    loaded_slots [$];

	fb_write_t           fb_writes_due [$];
	directed_row_t       directed_rows [$];

	logic [PIX_W-1:0]    seed_slots [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
		8'h0F, 8'hF0, 8'h3C, 8'hC3};
	logic [COLOUR_W-1:0] seed_words [8] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
		16'h1234, 16'hFEDC, 16'h8001, 16'h7FFE};

	int failures = 0;
	int cycle_count = 0;
	bit pace_source = 1'b1;
	bit pace_sink = 1'b1;
	bit sink_hold_req = 1'b0;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	task automatic log_failure(input string what);
		failures++;
		if (failures <= 10) begin
			$display("%s", what);
		end
	endtask

	// Applies one accepted request to the local state and, for blits, queues the
	// framebuffer writes it should produce.
	task automatic predict_request(input logic [1:0] fn, input tile_req_t rq, input bit emit);
		int row_lim, col_lim, ty, tx, x, y;
		logic [PIX_W-1:0] idx;
		fb_write_t pending;
		bit have_pending;
		case (fn)
			FUNC_LOAD_COLOUR: begin
				clut_shadow[rq.palette_slot] = rq.colour_word;
			end
			FUNC_LOAD_PIXEL: begin
				if (rq.pixel_offset < TILE_AREA) begin
					tile_shadow[rq.tile_index][rq.pixel_offset] = rq.pixel_value;
					tile_valid[rq.tile_index] = 1'b1;
				end
			end
			default: begin
				if (emit && tile_valid[rq.tile_index]) begin
					row_lim = (frame_height_q > MAX_Y_LIMIT) ? MAX_Y_LIMIT : frame_height_q;
					col_lim = (FB_WIDTH > MAX_Y_LIMIT) ? MAX_Y_LIMIT : FB_WIDTH;
					have_pending = 1'b0;
					for (ty = 0; ty < TILE_EDGE; ty++) begin
						y = $signed(rq.pos_y) + ty;
						if (y < 0 || y >= row_lim) continue;
						for (tx = 0; tx < TILE_EDGE; tx++) begin
							x = $signed(rq.pos_x) + tx;
							if (x < 0 || x >= col_lim) continue;
							idx = tile_shadow[rq.tile_index][(ty * TILE_EDGE + tx) % TILE_SLOTS];
							if (fn == FUNC_BLIT_MASKED && idx == transparent_q) continue;
							if (have_pending) fb_writes_due.push_back(pending);
							pending.x = x[COORD_W-1:0];
							pending.y = y[COORD_W-1:0];
							pending.colour = clut_shadow[idx];
							pending.last = 1'b0;
							have_pending = 1'b1;
						end
					end
					if (have_pending) begin
						pending.last = 1'b1;
						fb_writes_due.push_back(pending);
					end
				end
			end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input logic [1:0] fn, input tile_req_t rq,
		input logic [1:0] outcome, input fb_write_t typed);
		while (pace_source && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rq;
		s_tuser <= fn;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_request(fn, rq, outcome == OUTCOME_MODEL);
		if (outcome == OUTCOME_ONE) fb_writes_due.push_back(typed);
		@(negedge clk);
	endtask

	task automatic write_registers(input logic [FH_W-1:0] fh, input logic [PIX_W-1:0] ti);
		int n;
		for (n = 0; n < 2; n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (n == 0) ? REG_FRAME_HEIGHT : REG_TRANSPARENT;
			cfg_data <= (n == 0) ? fh : {3'b000, ti};
			do @(posedge clk); while (cfg_ready !== 1'b1);
			if (n == 0) frame_height_q = fh;
			else transparent_q = ti;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (fb_writes_due.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic tile_req_t random_request();
		tile_req_t rq;
		rq = tile_req_t'(72'({$urandom, $urandom, $urandom}));
		rq.pad = '0;
		return rq;
	endfunction

	function automatic logic [PIX_W-1:0] pick_loaded_slot();
		return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
	endfunction

	function automatic logic [POS_W-1:0] pick_coord(input int span);
		int v;
		if ($urandom_range(9) < 7) begin
			v = int'($urandom_range(span + 8)) - 8;
		end else begin
			v = int'($urandom);
		end
		return v[POS_W-1:0];
	endfunction

	task automatic fill_tile(input logic [TILE_AW-1:0] tile, input bit scramble, input int start);
		tile_req_t rq;
		int p;
		for (p = 0; p < TILE_AREA; p++) begin
			rq = random_request();
			rq.tile_index = tile;
			rq.pixel_offset = p[OFFS_W-1:0];
			rq.pixel_value = scramble ? pick_loaded_slot() : seed_slots[(p + start) % 8];
			send_request(FUNC_LOAD_PIXEL, rq, OUTCOME_NONE, '0);
		end
		tile_full[tile] = 1'b1;
		full_tiles.push_back(tile);
	endtask

	function automatic directed_row_t make_row(input logic [1:0] fn, input logic [7:0] tile,
		input logic [5:0] offs, input logic [7:0] pval, input logic [7:0] slot,
		input logic [15:0] cw, input int px, input int py, input logic [1:0] outcome,
		input int ex, input int ey, input logic [15:0] ecol);
		directed_row_t r;
		r = '0;
		r.fn = fn;
		r.rq.tile_index = tile;
		r.rq.pixel_offset = offs;
		r.rq.pixel_value = pval;
		r.rq.palette_slot = slot;
		r.rq.colour_word = cw;
		r.rq.pos_x = px[POS_W-1:0];
		r.rq.pos_y = py[POS_W-1:0];
		r.outcome = outcome;
		r.typed.x = ex[COORD_W-1:0];
		r.typed.y = ey[COORD_W-1:0];
		r.typed.colour = ecol;
		r.typed.last = 1'b1;
		return r;
	endfunction

	function automatic directed_row_t blit_row(input logic [1:0] fn, input logic [7:0] tile,
		input int px, input int py, input logic [1:0] outcome,
		input int ex, input int ey, input logic [15:0] ecol);
		return make_row(fn, tile, 0, 0, 0, 0, px, py, outcome, ex, ey, ecol);
	endfunction

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				m_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				sink_hold_req = 1'b0;
			end else begin
				m_tready <= !(pace_sink && $urandom_range(99) < 20);
			end
		end
	end

	always @(posedge clk) begin : check_fb_writes
		fb_write_t due;
		fb_word_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata;
			if (fb_writes_due.size() == 0) begin
				log_failure($sformatf("unexpected write x=%0d y=%0d colour=%h last=%b",
					seen.x, seen.y, seen.colour, m_tlast));
			end else begin
				due = fb_writes_due.pop_front();
				if (seen.x !== due.x || seen.y !== due.y || seen.colour !== due.colour ||
					m_tlast !== due.last) begin
					log_failure($sformatf({"write mismatch: expected x=%0d y=%0d colour=%h ",
						"last=%b, got x=%0d y=%0d colour=%h last=%b"}, due.x, due.y,
						due.colour, due.last, seen.x, seen.y, seen.colour, m_tlast));
				end
			end
		end
	end

	initial begin
		directed_row_t r;
		tile_req_t rq;
		logic [1:0] fn;
		logic [FH_W-1:0] fh;
		logic [PIX_W-1:0] ti;
		logic [TILE_AW-1:0] t;
		int phase, k, pick, i, row_span;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_height_q = FRAME_HEIGHT_RST;
		transparent_q = TRANSPARENT_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < 8; i++) begin
			rq = random_request();
			rq.palette_slot = seed_slots[i];
			rq.colour_word = seed_words[i];
			slot_loaded[seed_slots[i]] = 1'b1;
			loaded_slots.push_back(seed_slots[i]);
			send_request(FUNC_LOAD_COLOUR, rq, OUTCOME_NONE, '0);
		end
		fill_tile(8'h00, 1'b0, 0);
		fill_tile(8'hFF, 1'b0, 3);

		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h5A, 0, 0, OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_MASKED, 8'hA5, 0, 0, OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, -1024, -1024,
			OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'hFF, 1023, 1023,
			OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'hFF, 319, 319,
			OUTCOME_ONE, 319, 319, 16'hAAAA));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'hFF, -7, -7,
			OUTCOME_ONE, 0, 0, 16'h5555));
		directed_rows.push_back(blit_row(FUNC_BLIT_MASKED, 8'h00, 319, 319,
			OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, 319, 319,
			OUTCOME_ONE, 319, 319, 16'h0000));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, 0, 0, OUTCOME_MODEL, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_MASKED, 8'h00, 0, 0, OUTCOME_MODEL, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'hFF, -3, 316,
			OUTCOME_MODEL, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_MASKED, 8'hFF, 315, -4,
			OUTCOME_MODEL, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, 312, -1,
			OUTCOME_MODEL, 0, 0, 0));
		directed_rows.push_back(make_row(FUNC_LOAD_COLOUR, 0, 0, 0, 8'h00, 16'hBEEF, 0, 0,
			OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, 319, 319,
			OUTCOME_ONE, 319, 319, 16'hBEEF));
		directed_rows.push_back(make_row(FUNC_LOAD_PIXEL, 8'h00, 6'd63, 8'hFF, 0, 0, 0, 0,
			OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, -7, -7,
			OUTCOME_ONE, 0, 0, 16'hFFFF));
		directed_rows.push_back(make_row(FUNC_LOAD_PIXEL, 8'h00, 6'd0, 8'h55, 0, 0, 0, 0,
			OUTCOME_NONE, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_MASKED, 8'h00, 319, 319,
			OUTCOME_ONE, 319, 319, 16'h5555));
		directed_rows.push_back(blit_row(FUNC_BLIT_MASKED, 8'hFF, 100, 200,
			OUTCOME_MODEL, 0, 0, 0));
		directed_rows.push_back(blit_row(FUNC_BLIT_OPAQUE, 8'h00, 316, 300,
			OUTCOME_MODEL, 0, 0, 0));

		for (i = 0; i < directed_rows.size(); i++) begin
			r = directed_rows[i];
			send_request(r.fn, r.rq, r.outcome, r.typed);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: begin fh = 11'd1;    ti = 8'hFF; end
				1: begin fh = 11'd1024; ti = 8'h00; end
				2: begin fh = 11'd2047; ti = 8'h55; end
				3: begin fh = 11'd0;    ti = 8'hAA; end
				4: begin fh = 11'd200;  ti = pick_loaded_slot(); end
				default: begin fh = 11'd320; ti = pick_loaded_slot(); end
			endcase
			write_registers(fh, ti);
			row_span = (fh == 0) ? 16 : ((fh > MAX_Y_LIMIT) ? MAX_Y_LIMIT : fh);
			pace_source = (phase != 2);
			pace_sink = (phase != 2);
			if (phase == 1) begin
				do t = TILE_AW'($urandom_range(TILE_COUNT - 1)); while (tile_valid[t]);
				fill_tile(t, 1'b1, 0);
				sink_hold_req = 1'b1;
			end
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				rq = random_request();
				pick = $urandom_range(99);
				if (pick < 55) begin
					fn = $urandom_range(1) ? FUNC_BLIT_MASKED : FUNC_BLIT_OPAQUE;
					if (pick < 45) begin
						rq.tile_index = full_tiles[$urandom_range(full_tiles.size() - 1)];
					end else begin
						do t = TILE_AW'($urandom_range(TILE_COUNT - 1)); while (tile_valid[t]);
						rq.tile_index = t;
					end
					rq.pos_x = pick_coord(FB_WIDTH);
					rq.pos_y = pick_coord(row_span);
				end else if (pick < 80) begin
					fn = FUNC_LOAD_PIXEL;
					rq.tile_index = full_tiles[$urandom_range(full_tiles.size() - 1)];
					rq.pixel_value = pick_loaded_slot();
				end else if (pick < 92) begin
					fn = FUNC_LOAD_COLOUR;
					if (!slot_loaded[rq.palette_slot]) begin
						slot_loaded[rq.palette_slot] = 1'b1;
						loaded_slots.push_back(rq.palette_slot);
					end
				end else begin
					// Stray pixel loads land only on tiles outside the fully loaded set that blits draw from.
					fn = FUNC_LOAD_PIXEL;
					do t = TILE_AW'($urandom_range(TILE_COUNT - 1)); while (tile_full[t]);
					rq.tile_index = t;
				end
				send_request(fn, rq, OUTCOME_MODEL, '0);
			end
		end

		pace_source = 1'b1;
		pace_sink = 1'b1;
		settle();
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/clutb_pkg.sv
rtl/core/clutb_store.sv
rtl/core/clutb_seq.sv
rtl/core/clut_tile_blitter.sv
rtl/core/clutb_checker.sv
tb/testbench.sv
